### hw/rtl/pldf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pldf_pkg;

    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_PERIOD      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_GAIN_DIV   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQ_GAIN        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CORRECTION_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_INTERVAL    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STEPPING_ON      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCKING_ON       = 3'd6;

    localparam logic [15:0] RST_LOOP_PERIOD      = 16'd16880;
    localparam logic [7:0]  RST_PHASE_GAIN_DIV   = 8'd100;
    localparam logic [7:0]  RST_FREQ_GAIN        = 8'd0;
    localparam logic [15:0] RST_CORRECTION_LIMIT = 16'd8192;
    localparam logic [15:0] RST_STEP_INTERVAL    = 16'd300;
    localparam logic [15:0] RST_DAC_LEVEL        = 16'd32768;
    localparam logic [15:0] RST_TARGET_DELAY     = RST_LOOP_PERIOD >> 1;

    localparam int unsigned DIV_STEPS = 16;

    typedef enum logic [1:0] {
        OP_CAPTURE = 2'd0,
        OP_UNLOCK  = 2'd1,
        OP_LOAD    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_INIT,
        ST_DIV,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] loop_period;
        logic [7:0]  phase_gain_divisor;
        logic [7:0]  freq_gain;
        logic [15:0] correction_limit;
        logic [15:0] step_interval;
        logic        stepping_on;
        logic        locking_on;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic div_init;
        logic div_step;
        logic apply;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic corr_needed;
        logic div_last;
    } status_t;

endpackage
`default_nettype wire

### hw/rtl/pldf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module pldf_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pldf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output pldf_pkg::cfg_t                   cfg
);
    import pldf_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_period        <= RST_LOOP_PERIOD;
            cfg_reg.phase_gain_divisor <= RST_PHASE_GAIN_DIV;
            cfg_reg.freq_gain          <= RST_FREQ_GAIN;
            cfg_reg.correction_limit   <= RST_CORRECTION_LIMIT;
            cfg_reg.step_interval      <= RST_STEP_INTERVAL;
            cfg_reg.stepping_on        <= 1'b0;
            cfg_reg.locking_on         <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOOP_PERIOD:      cfg_reg.loop_period        <= cfg_data;
                REG_PHASE_GAIN_DIV:   cfg_reg.phase_gain_divisor <= cfg_data[7:0];
                REG_FREQ_GAIN:        cfg_reg.freq_gain          <= cfg_data[7:0];
                REG_CORRECTION_LIMIT: cfg_reg.correction_limit   <= cfg_data;
                REG_STEP_INTERVAL:    cfg_reg.step_interval      <= cfg_data;
                REG_STEPPING_ON:      cfg_reg.stepping_on        <= cfg_data[0];
                REG_LOCKING_ON:       cfg_reg.locking_on         <= cfg_data[0];
                default:              ;
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/pldf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pldf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pldf_pkg::status_t status,
    output pldf_pkg::cmd_t    cmd
);
    import pldf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.corr_needed ? ST_DIV_INIT : ST_DONE;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/pldf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pldf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  pldf_pkg::cfg_t    cfg,
    input  pldf_pkg::cmd_t    cmd,
    output pldf_pkg::status_t status,
    input  logic [1:0]        in_op,
    input  logic [15:0]       in_compare_value,
    input  logic [15:0]       in_capture_value,
    input  logic [15:0]       in_dac_load_value,
    output logic [15:0]       dac_level_out,
    output logic              dac_changed,
    output logic [15:0]       measured_delay,
    output logic [15:0]       setpoint_out
);
    import pldf_pkg::*;

    // item latch
    op_t         op_reg;
    logic [15:0] compare_reg;
    logic [15:0] capture_reg;
    logic [15:0] load_reg;

    // loop state
    logic [15:0] dac_level_reg;
    logic [15:0] last_delay_reg;
    logic [15:0] prior_delay_reg;
    logic [15:0] target_delay_reg;
    logic [15:0] step_count_reg;
    logic        step_phase_reg;
    logic        changed_reg;

    // correction work registers
    logic        pos_reg;
    logic [15:0] prod_reg;
    logic [7:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [3:0]  div_cnt_reg;

    // result registers
    logic [15:0] out_dac_reg;
    logic        out_changed_reg;
    logic [15:0] out_delay_reg;
    logic [15:0] out_setpoint_reg;

    logic [15:0] diff;
    logic [15:0] folded;
    logic [7:0]  divisor;
    logic [8:0]  rem_shift;
    logic        quo_bit;
    logic [7:0]  rem_next;
    logic [15:0] corr;
    logic [15:0] dac_next;
    logic [15:0] step_count_inc;
    logic [13:0] quarter;
    logic [15:0] setpoint_hi;
    logic [15:0] setpoint_lo;
    logic [15:0] delay_delta;
    logic [23:0] prod_full;

    assign diff    = compare_reg - capture_reg;
    assign folded  = (diff < cfg.loop_period) ? diff : 16'(16'd0 - diff);
    assign divisor = (cfg.phase_gain_divisor == 8'd0) ? 8'd1 : cfg.phase_gain_divisor;

    assign rem_shift = {rem_reg, quo_reg[15]};
    assign quo_bit   = (rem_shift >= {1'b0, divisor});
    assign rem_next  = quo_bit ? 8'(rem_shift - {1'b0, divisor}) : rem_shift[7:0];

    assign delay_delta = last_delay_reg - prior_delay_reg;
    assign prod_full   = cfg.freq_gain * delay_delta;

    assign corr     = (quo_reg > cfg.correction_limit) ? cfg.correction_limit : quo_reg;
    assign dac_next = pos_reg ? (dac_level_reg - prod_reg - corr)
                              : (dac_level_reg - prod_reg + corr);

    assign step_count_inc = step_count_reg + 16'd1;
    assign quarter        = cfg.loop_period[15:2];
    assign setpoint_lo    = {quarter, 2'b00} >> 1;
    assign setpoint_hi    = 16'({quarter, 1'b0}) + 16'(quarter);

    assign status.corr_needed = (op_reg == OP_CAPTURE) && cfg.locking_on
                                && (last_delay_reg < cfg.loop_period);
    assign status.div_last    = (div_cnt_reg == 4'(DIV_STEPS - 1));

    assign dac_level_out  = out_dac_reg;
    assign dac_changed    = out_changed_reg;
    assign measured_delay = out_delay_reg;
    assign setpoint_out   = out_setpoint_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= op_t'(in_op);
            compare_reg <= in_compare_value;
            capture_reg <= in_capture_value;
            load_reg    <= in_dac_load_value;
        end
        if (cmd.div_init)
        begin
            pos_reg     <= (last_delay_reg > target_delay_reg);
            prod_reg    <= prod_full[15:0];
            rem_reg     <= '0;
            quo_reg     <= (last_delay_reg > target_delay_reg)
                           ? (last_delay_reg - target_delay_reg)
                           : (target_delay_reg - last_delay_reg);
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            quo_reg     <= {quo_reg[14:0], quo_bit};
            div_cnt_reg <= div_cnt_reg + 4'd1;
        end
        if (cmd.out_load)
        begin
            out_dac_reg      <= dac_level_reg;
            out_changed_reg  <= changed_reg;
            out_delay_reg    <= last_delay_reg;
            out_setpoint_reg <= target_delay_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_level_reg    <= RST_DAC_LEVEL;
            last_delay_reg   <= RST_LOOP_PERIOD;
            prior_delay_reg  <= RST_LOOP_PERIOD;
            target_delay_reg <= RST_TARGET_DELAY;
            step_count_reg   <= '0;
            step_phase_reg   <= 1'b0;
            changed_reg      <= 1'b0;
        end
        else if (cmd.exec)
        begin
            changed_reg <= 1'b0;
            unique case (op_reg)
                OP_CAPTURE:
                begin
                    prior_delay_reg <= last_delay_reg;
                    last_delay_reg  <= folded;
                end
                OP_UNLOCK:
                begin
                    target_delay_reg <= cfg.loop_period >> 1;
                    step_phase_reg   <= 1'b0;
                end
                OP_LOAD:
                begin
                    dac_level_reg <= load_reg;
                    changed_reg   <= 1'b1;
                end
                default: ;
            endcase
        end
        else if (cmd.apply)
        begin
            dac_level_reg <= dac_next;
            changed_reg   <= 1'b1;
            if (cfg.stepping_on)
            begin
                if (step_count_inc == cfg.step_interval)
                begin
                    step_count_reg   <= '0;
                    step_phase_reg   <= !step_phase_reg;
                    target_delay_reg <= step_phase_reg ? setpoint_lo : setpoint_hi;
                end
                else
                begin
                    step_count_reg <= step_count_inc;
                end
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/phase_lock_dac_feedback_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Phase-lock DAC feedback loop. Each input beat is a capture event, an unlock
// restart, a DAC load or a no-op (selected by s_tuser) and yields exactly one output beat
// with the DAC level, a changed flag, the folded capture delay and the current
// setpoint. Items are processed one at a time: a no-op, unlock, load or capture
// that makes no correction goes from EXEC straight to DONE; a correcting capture
// passes DIV_INIT, the 16-step restoring divider that scales the phase error, and APPLY.
// A finished result sits in the output register while the next beat is taken.
// Configuration writes are accepted every cycle and must be issued while idle;
// indexes above 6 are ignored.
module phase_lock_dac_feedback_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // compare_value, capture_value, dac_load_value
    input  logic [1:0]                       s_tuser,  // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,  // dac_level_out, measured_delay, setpoint_out
    output logic                             m_tuser,  // dac_changed
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pldf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    import pldf_pkg::*;

    cfg_t        cfg;
    cmd_t        cmd;
    status_t     status;
    logic [15:0] dac_level_out;
    logic [15:0] measured_delay;
    logic [15:0] setpoint_out;

    pldf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pldf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pldf_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd               (cmd),
        .status            (status),
        .in_op             (s_tuser),
        .in_compare_value  (s_tdata[15:0]),
        .in_capture_value  (s_tdata[31:16]),
        .in_dac_load_value (s_tdata[47:32]),
        .dac_level_out     (dac_level_out),
        .dac_changed       (m_tuser),
        .measured_delay    (measured_delay),
        .setpoint_out      (setpoint_out)
    );

    assign m_tdata = {setpoint_out, measured_delay, dac_level_out};

endmodule
`default_nettype wire

### tb/phase_lock_dac_feedback_checker.sv
`timescale 1ns / 1ps
module phase_lock_dac_feedback_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [47:0]                      s_tdata,
    input  logic [1:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [47:0]                      m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [pldf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output int                               outstanding,
    output int                               errors
);
    import pldf_pkg::*;

    typedef struct packed {
        logic [15:0] dac_level;
        logic        changed;
        logic [15:0] delay;
        logic [15:0] setpoint;
    } dac_report_t;

    cfg_t        regs;
    logic [15:0] dac_level;
    logic [15:0] last_delay;
    logic [15:0] prior_delay;
    logic [15:0] target_delay;
    logic [15:0] step_count;
    logic        step_phase;
    dac_report_t reports_due[$];

    function automatic logic [15:0] fold_delay(input logic [15:0] cmp, input logic [15:0] cap);
        logic [15:0] d;
        d = cmp - cap;
        return (d < regs.loop_period) ? d : 16'(-d);
    endfunction

    function void apply_correction();
        logic [15:0] div;
        logic [15:0] mag;
        logic [15:0] corr;
        logic [15:0] total;
        logic        pos;
        div = (regs.phase_gain_divisor == 8'd0) ? 16'd1 : {8'd0, regs.phase_gain_divisor};
        pos = last_delay > target_delay;
        mag = pos ? last_delay - target_delay : target_delay - last_delay;
        corr = mag / div;
        if (corr > regs.correction_limit)
        begin
            corr = regs.correction_limit;
        end
        total = regs.freq_gain * (last_delay - prior_delay);
        total = pos ? total + corr : total - corr;
        dac_level = dac_level - total;
        if (regs.stepping_on)
        begin
            step_count = step_count + 16'd1;
            if (step_count == regs.step_interval)
            begin
                step_count = 16'd0;
                step_phase = ~step_phase;
                target_delay = (step_phase ? 16'd3 : 16'd2) * (regs.loop_period >> 2);
            end
        end
    endfunction

    function void predict_report(input op_t op, input logic [47:0] data);
        dac_report_t r;
        logic        changed;
        changed = 1'b0;
        case (op)
            OP_CAPTURE:
            begin
                prior_delay = last_delay;
                last_delay = fold_delay(data[15:0], data[31:16]);
                if (regs.locking_on && prior_delay < regs.loop_period)
                begin
                    apply_correction();
                    changed = 1'b1;
                end
            end
            OP_UNLOCK:
            begin
                target_delay = regs.loop_period >> 1;
                step_phase = 1'b0;
            end
            OP_LOAD:
            begin
                dac_level = data[47:32];
                changed = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.dac_level = dac_level;
        r.changed = changed;
        r.delay = last_delay;
        r.setpoint = target_delay;
        reports_due.push_back(r);
    endfunction

    function void check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dac_report_t got;
        dac_report_t want;
        if (!rst_n)
        begin
            regs.loop_period = RST_LOOP_PERIOD;
            regs.phase_gain_divisor = RST_PHASE_GAIN_DIV;
            regs.freq_gain = RST_FREQ_GAIN;
            regs.correction_limit = RST_CORRECTION_LIMIT;
            regs.step_interval = RST_STEP_INTERVAL;
            regs.stepping_on = 1'b0;
            regs.locking_on = 1'b0;
            dac_level = RST_DAC_LEVEL;
            last_delay = RST_LOOP_PERIOD;
            prior_delay = RST_LOOP_PERIOD;
            target_delay = RST_TARGET_DELAY;
            step_count = 16'd0;
            step_phase = 1'b0;
            reports_due.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOOP_PERIOD:      regs.loop_period = cfg_data;
                    REG_PHASE_GAIN_DIV:   regs.phase_gain_divisor = cfg_data[7:0];
                    REG_FREQ_GAIN:        regs.freq_gain = cfg_data[7:0];
                    REG_CORRECTION_LIMIT: regs.correction_limit = cfg_data;
                    REG_STEP_INTERVAL:    regs.step_interval = cfg_data;
                    REG_STEPPING_ON:      regs.stepping_on = cfg_data[0];
                    REG_LOCKING_ON:       regs.locking_on = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tuser, m_tdata[31:16], m_tdata[47:32]};
                if (reports_due.size() == 0)
                begin
                    $error("result beat with no pending item");
                    errors++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("dac_level_out", want.dac_level, got.dac_level);
                    check_field("dac_changed", {15'd0, want.changed}, {15'd0, got.changed});
                    check_field("measured_delay", want.delay, got.delay);
                    check_field("setpoint_out", want.setpoint, got.setpoint);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_report(op_t'(s_tuser), s_tdata);
            end
            outstanding <= reports_due.size();
        end
    end

endmodule

### tb/phase_lock_dac_feedback_top_test.sv
`timescale 1ns / 1ps
module phase_lock_dac_feedback_top_test;
    import pldf_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 200;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [47:0]            s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [47:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;
    int                     outstanding;
    int                     errors;
    int                     cycle_count;
    bit                     calm;
    bit                     hold_off_req;
    logic [15:0]            cur_period;

    phase_lock_dac_feedback_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    phase_lock_dac_feedback_checker loop_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_draw();
        return calm ? 0 : int'($urandom_range(17, 0));
    endfunction

    function automatic logic [15:0] pick_value(input int phase, input logic [15:0] lo,
                                              input logic [15:0] hi, input logic [15:0] typical);
        if (phase == 0)
        begin
            return lo;
        end
        if (phase == 1)
        begin
            return hi;
        end
        case ($urandom_range(3, 0))
            0:       return lo;
            1:       return hi;
            default: return 16'($urandom_range(typical, lo));
        endcase
    endfunction

    task automatic send_beat(input op_t op, input logic [15:0] cmp, input logic [15:0] cap,
                             input logic [15:0] load);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {load, cap, cmp};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure_phase(input int phase);
        logic [15:0] period;
        logic [15:0] pgd;
        logic [15:0] fg;
        logic [15:0] lim;
        logic [15:0] step;
        logic        step_on;
        logic        lock_on;
        period = pick_value(phase, 16'd1, 16'hFFFF, 16'hFFFF);
        pgd = pick_value(phase, 16'd0, 16'd255, 16'd255);
        fg = pick_value(phase, 16'd0, 16'd255, 16'd255);
        lim = pick_value(phase, 16'd0, 16'hFFFF, 16'hFFFF);
        // zero interval only matches on count wrap
        step = pick_value(phase, 16'd0, 16'hFFFF, 16'd40);
        step_on = (phase < 2) ? phase[0] : 1'($urandom_range(1, 0));
        lock_on = (phase < 2) ? 1'b1 : ($urandom_range(3, 0) != 0);
        write_reg(REG_LOOP_PERIOD, period);
        write_reg(REG_PHASE_GAIN_DIV, {8'($urandom), pgd[7:0]});
        write_reg(REG_FREQ_GAIN, {8'($urandom), fg[7:0]});
        write_reg(REG_CORRECTION_LIMIT, lim);
        write_reg(REG_STEP_INTERVAL, step);
        write_reg(REG_STEPPING_ON, {15'($urandom), step_on});
        write_reg(REG_LOCKING_ON, {15'($urandom), lock_on});
        cur_period = period;
    endtask

    task automatic random_beat();
        int          pick;
        logic [15:0] cmp;
        logic [15:0] delay;
        pick = $urandom_range(99, 0);
        cmp = 16'($urandom);
        if (pick < 70)
        begin
            delay = 16'($urandom_range(cur_period - 16'd1, 0));
            send_beat(OP_CAPTURE, cmp, cmp - delay, 16'($urandom));
        end
        else if (pick < 82)
        begin
            send_beat(OP_CAPTURE, cmp, 16'($urandom), 16'($urandom));
        end
        else if (pick < 90)
        begin
            send_beat(OP_LOAD, cmp, 16'($urandom), 16'($urandom));
        end
        else if (pick < 96)
        begin
            send_beat(OP_UNLOCK, cmp, 16'($urandom), 16'($urandom));
        end
        else
        begin
            send_beat(OP_NONE, cmp, 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("phase_lock_dac_feedback_top_test NOT OK");
        $finish;
    end

    initial
    begin : sink
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            stall = idle_draw();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_CAPTURE;
        cfg_valid <= 1'b0;
        cfg_index <= REG_LOOP_PERIOD;
        cfg_data <= '0;
        calm = 1'b0;
        hold_off_req = 1'b0;
        cur_period = RST_LOOP_PERIOD;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, lock off
        send_beat(OP_CAPTURE, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_CAPTURE, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_beat(OP_CAPTURE, 16'h0000, 16'hFFFF, 16'h0000);
        send_beat(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_LOAD, 16'h1234, 16'h4321, 16'h0000);
        send_beat(OP_LOAD, 16'h0000, 16'h0000, 16'hFFFF);
        send_beat(OP_UNLOCK, 16'hFFFF, 16'h0000, 16'hFFFF);
        drain();

        // max period, divisor zero after masking, swap on every correction
        write_reg(REG_LOOP_PERIOD, 16'hFFFF);
        write_reg(REG_PHASE_GAIN_DIV, 16'hFF00);
        write_reg(REG_FREQ_GAIN, 16'h00FF);
        write_reg(REG_CORRECTION_LIMIT, 16'hFFFF);
        write_reg(REG_STEP_INTERVAL, 16'd1);
        write_reg(REG_STEPPING_ON, 16'hFFFF);
        write_reg(REG_LOCKING_ON, 16'h0001);
        write_reg(REG_UNUSED, 16'hFFFF);
        cur_period = 16'hFFFF;
        send_beat(OP_CAPTURE, 16'd1000, 16'd0, 16'd0);
        send_beat(OP_CAPTURE, 16'hFFFE, 16'd0, 16'd0);
        send_beat(OP_CAPTURE, 16'hFFFF, 16'hFFFF, 16'd0);
        send_beat(OP_UNLOCK, 16'd0, 16'd0, 16'd0);
        send_beat(OP_CAPTURE, 16'h8000, 16'h0001, 16'd0);
        send_beat(OP_LOAD, 16'd0, 16'd0, 16'h8000);
        send_beat(OP_CAPTURE, 16'h0100, 16'h0000, 16'd0);
        drain();

        // period of one: old delay above period blocks the first correction
        write_reg(REG_LOOP_PERIOD, 16'd1);
        write_reg(REG_PHASE_GAIN_DIV, 16'h00FF);
        write_reg(REG_FREQ_GAIN, 16'd0);
        write_reg(REG_CORRECTION_LIMIT, 16'd0);
        write_reg(REG_STEP_INTERVAL, 16'd0);
        cur_period = 16'd1;
        send_beat(OP_CAPTURE, 16'h0100, 16'h0000, 16'd0);
        send_beat(OP_CAPTURE, 16'h5555, 16'h5555, 16'd0);
        send_beat(OP_CAPTURE, 16'hAAAA, 16'hAAAA, 16'd0);
        send_beat(OP_CAPTURE, 16'h0001, 16'h0000, 16'd0);
        send_beat(OP_UNLOCK, 16'd0, 16'd0, 16'd0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            configure_phase(phase);
            calm = (phase % 4 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 3 && n == 40)
                begin
                    hold_off_req = 1'b1;
                end
                random_beat();
            end
        end
        drain();

        if (errors == 0)
        begin
            $display("phase_lock_dac_feedback_top_test OK");
        end
        else
        begin
            $display("phase_lock_dac_feedback_top_test NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pldf_pkg.sv
hw/rtl/pldf_cfg.sv
hw/rtl/pldf_ctrl.sv
hw/rtl/pldf_datapath.sv
hw/rtl/phase_lock_dac_feedback_top.sv
tb/phase_lock_dac_feedback_checker.sv
tb/phase_lock_dac_feedback_top_test.sv
